@@ src/epg_pkg.sv @@
// shared constants, types and the arctangent table of the ellipse point generator
package epg_pkg;

  // number of rotation stages in the cordic chain (8 to 32)
  localparam int CORDIC_STAGES = 16;

  // width of the cordic x, y and z datapath (q2.30 with headroom)
  localparam int TRIG_W = 33;

  // 1/(2*pi) in q0.32 turns per radian
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  // 1/360 in q0.32 turns per degree
  localparam logic [23:0] TURN_PER_DEG = 24'd11930465;
  // start vector of the rotation, cordic gain compensated, q2.30
  localparam logic [TRIG_W-1:0] CORDIC_GAIN = 33'd652032874;
  // rounding offset for the q.46 to q16.16 step
  localparam logic signed [64:0] ROUND_HALF = 65'sd536870912;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_SPEED     = 3'd4,
    REG_PHASE_DEG = 3'd5
  } reg_idx_e;

  // state handed from one cordic stage to the next
  typedef struct packed {
    logic              valid;
    logic              flip;
    logic [TRIG_W-1:0] x;
    logic [TRIG_W-1:0] y;
    logic [TRIG_W-1:0] z;
  } cordic_t;

  // arctangent of 2^-idx in turns, 2^32 to a full turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/epg_angle.sv @@
// time stamp to angle pipeline: time*speed, turn reduction, phase add and quadrant fold
module epg_angle (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [47:0]           time_stamp_i,
  input  logic signed [23:0]    speed_i,
  input  logic [31:0]           phase_turn_i,
  output epg_pkg::cordic_t      st_o
);

  logic [2:0]         v_q;
  logic signed [56:0] mlo_q;
  logic [31:0]        mhi_q;
  logic [63:0]        p_q;
  logic [61:0]        plo_q;
  logic [31:0]        phi_q;
  epg_pkg::cordic_t   st_q;

  logic signed [40:0] mhi_full;
  logic [63:0]        p_d;
  logic [61:0]        phi_full;
  logic [31:0]        ang;
  logic               flip;
  logic               zt;

  // partial products of time*speed, result only needed modulo 2^64
  always_comb begin
    mhi_full = $signed({1'b0, time_stamp_i[47:32]}) * speed_i;
    p_d      = {{7{mlo_q[56]}}, mlo_q} + {mhi_q, 32'd0};
    phi_full = p_q[63:32] * epg_pkg::TURN_PER_RAD;
  end

  // turn fraction plus phase, fold the left half plane onto the right
  always_comb begin
    ang  = {2'b00, plo_q[61:32]} + phi_q + phase_turn_i;
    flip = ang[31] ^ ang[30];
    zt   = ang[31] ^ flip;
  end

  // valid pipeline and the hand-off register to the cordic chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      st_q <= '0;
    end else if (en_i) begin
      v_q        <= {v_q[1:0], valid_i};
      st_q.valid <= v_q[2];
      st_q.flip  <= flip;
      st_q.x     <= epg_pkg::CORDIC_GAIN;
      st_q.y     <= '0;
      st_q.z     <= {zt, zt, ang[30:0]};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mlo_q     <= $signed({1'b0, time_stamp_i[31:0]}) * speed_i;
      mhi_q     <= mhi_full[31:0];
      p_q       <= p_d;
      plo_q     <= p_q[31:0] * epg_pkg::TURN_PER_RAD;
      phi_q     <= phi_full[31:0];
    end
  end

  assign st_o = st_q;

endmodule

@@ src/epg_cordic_cell.sv @@
// one rotation-mode cordic stage of the chain
module epg_cordic_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [4:0]       idx_i,
  input  epg_pkg::cordic_t st_i,
  output epg_pkg::cordic_t st_o
);

  epg_pkg::cordic_t st_q;
  epg_pkg::cordic_t st_d;

  logic signed [epg_pkg::TRIG_W-1:0] xs;
  logic signed [epg_pkg::TRIG_W-1:0] ys;
  logic signed [epg_pkg::TRIG_W-1:0] zs;
  logic signed [epg_pkg::TRIG_W-1:0] dx;
  logic signed [epg_pkg::TRIG_W-1:0] dy;
  logic signed [epg_pkg::TRIG_W-1:0] atn;

  // micro-rotation towards zero residual angle
  always_comb begin
    xs  = $signed(st_i.x);
    ys  = $signed(st_i.y);
    zs  = $signed(st_i.z);
    dx  = ys >>> idx_i;
    dy  = xs >>> idx_i;
    atn = $signed({1'b0, epg_pkg::atan_turn(idx_i)});
    st_d       = st_i;
    if (!zs[epg_pkg::TRIG_W-1]) begin
      st_d.x = xs - dx;
      st_d.y = ys + dy;
      st_d.z = zs - atn;
    end else begin
      st_d.x = xs + dx;
      st_d.y = ys - dy;
      st_d.z = zs + atn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

@@ src/epg_scale.sv @@
// one output axis: unfold, multiply by the radius, round, add centre and saturate
module epg_scale (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [epg_pkg::TRIG_W-1:0]         trig_i,
  input  logic                               flip_i,
  input  logic signed [31:0]                 size_i,
  input  logic signed [31:0]                 center_i,
  output logic [31:0]                        point_o
);

  logic signed [epg_pkg::TRIG_W-1:0] neg_q;
  logic signed [64:0]                prod_q;
  logic signed [34:0]                rnd_q;

  logic signed [64:0] sum_r;
  logic signed [64:0] shr;
  logic signed [35:0] tot;

  // rounding half up, the centre offset and saturation
  always_comb begin
    sum_r = prod_q + epg_pkg::ROUND_HALF;
    shr   = sum_r >>> 30;
    tot   = $signed({rnd_q[34], rnd_q}) + $signed({{4{center_i[31]}}, center_i});
    if (tot > 36'sd2147483647) begin
      point_o = 32'h7FFF_FFFF;
    end else if (tot < -36'sd2147483648) begin
      point_o = 32'h8000_0000;
    end else begin
      point_o = tot[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= flip_i ? -$signed(trig_i) : $signed(trig_i);
      prod_q <= neg_q * size_i;
      rnd_q  <= shr[34:0];
    end
  end

endmodule

@@ src/ellipse_point_generator.sv @@
// ellipse point generator top level: configuration registers, cordic chain and output skid
//
// One time stamp (unsigned q32.16 seconds) goes in per input transaction and one
// point (point_x, point_y, signed q16.16, saturated) comes out per output
// transaction, in order. A transaction on either channel completes at a rising
// edge where valid is high and stall is low.
// The path from input transaction to out_valid_o runs through four angle stages,
// one register per cordic stage, three scaling stages and the output register.
// Throughput is one item per cycle while in_stall_o is low;
// every stage advances together and the chain is one rotation per stage.
// When the receiver stalls, the output register holds its point and one more
// finished point lands in a skid register; in_stall_o then rises and the whole
// pipeline freezes until the receiver takes the held point.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; indexes 0..5 are size_x, size_y, center_x, center_y, speed,
// phase_deg, other indexes are ignored. Write it only while no item is in flight.
// Reset empties the pipeline and loads unit radii, zero centre, speed 0.1 rad/s
// and zero phase.
module ellipse_point_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] time_stamp_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int N = epg_pkg::CORDIC_STAGES;

  logic signed [31:0] size_x_q;
  logic signed [31:0] size_y_q;
  logic signed [31:0] center_x_q;
  logic signed [31:0] center_y_q;
  logic signed [23:0] speed_q;
  logic [31:0]        phase_turn_q;

  logic signed [44:0] ph_prod;
  logic               en;
  logic [2:0]         sv_q;
  logic [31:0]        px;
  logic [31:0]        py;

  logic               out_valid_q;
  logic               skid_valid_q;
  logic [31:0]        out_x_q;
  logic [31:0]        out_y_q;
  logic [31:0]        skid_x_q;
  logic [31:0]        skid_y_q;
  logic               out_free;

  epg_pkg::cordic_t chain_st [N+1];

  // configuration writes, phase kept as a turn fraction
  assign cfg_ready_o = 1'b1;
  assign ph_prod     = $signed(cfg_data_i[19:0]) * $signed({1'b0, epg_pkg::TURN_PER_DEG});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= 32'sd65536;
      size_y_q     <= 32'sd65536;
      center_x_q   <= '0;
      center_y_q   <= '0;
      speed_q      <= 24'sd6554;
      phase_turn_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (epg_pkg::reg_idx_e'(cfg_index_i))
        epg_pkg::REG_SIZE_X:    size_x_q     <= $signed(cfg_data_i);
        epg_pkg::REG_SIZE_Y:    size_y_q     <= $signed(cfg_data_i);
        epg_pkg::REG_CENTER_X:  center_x_q   <= $signed(cfg_data_i);
        epg_pkg::REG_CENTER_Y:  center_y_q   <= $signed(cfg_data_i);
        epg_pkg::REG_SPEED:     speed_q      <= $signed(cfg_data_i[23:0]);
        epg_pkg::REG_PHASE_DEG: phase_turn_q <= ph_prod[39:8];
        default: ;
      endcase
    end
  end

  // the pipeline moves whenever the skid register is empty
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // angle computation
  epg_angle u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .time_stamp_i (time_stamp_i),
    .speed_i      (speed_q),
    .phase_turn_i (phase_turn_q),
    .st_o         (chain_st[0])
  );

  // chain of cordic stages
  for (genvar i = 0; i < N; i++) begin : g_cordic
    epg_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (5'(i)),
      .st_i   (chain_st[i]),
      .st_o   (chain_st[i+1])
    );
  end

  // scaling per axis
  epg_scale u_scale_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .trig_i   (chain_st[N].x),
    .flip_i   (chain_st[N].flip),
    .size_i   (size_x_q),
    .center_i (center_x_q),
    .point_o  (px)
  );

  epg_scale u_scale_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .trig_i   (chain_st[N].y),
    .flip_i   (chain_st[N].flip),
    .size_i   (size_y_q),
    .center_i (center_y_q),
    .point_o  (py)
  );

  // valid bits alongside the scaling stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[1:0], chain_st[N].valid};
    end
  end

  // output register and skid control
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= en && sv_q[2];
      end
    end else if (en && sv_q[2]) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
      end else if (en && sv_q[2]) begin
        out_x_q <= px;
        out_y_q <= py;
      end
    end else if (en && sv_q[2]) begin
      skid_x_q <= px;
      skid_y_q <= py;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = out_x_q;
  assign point_y_o   = out_y_q;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the ellipse point generator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes the block does not decode
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  // pipeline depth for the final wait and rotation count used by the angle model
  localparam int PIPE_DEPTH = epg_pkg::CORDIC_STAGES + 8;
  localparam int ROT_STAGES = (epg_pkg::CORDIC_STAGES > 32) ? 32 : epg_pkg::CORDIC_STAGES;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } point_t;

  typedef struct packed {
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] speed;
    logic [31:0] phase;
  } cfg_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [47:0] time_stamp_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] point_x_o;
  logic [31:0] point_y_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // time stamps waiting to be sent and points still owed by the block
  logic [47:0] stamps_to_send [$];
  point_t      points_due [$];
  point_t      oldest_point;

  // shadow copy of the configuration registers
  longint shadow_size_x = 65536;
  longint shadow_size_y = 65536;
  longint shadow_center_x = 0;
  longint shadow_center_y = 0;
  longint shadow_speed = 6554;
  longint shadow_phase = 0;

  // arctangent of 2^-i in turns, 2^32 to one turn
  longint atan_step [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  ellipse_point_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .time_stamp_i (time_stamp_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // radius scaling with round half up, centre offset and saturation
  function automatic logic [31:0] scale_axis(input longint trig, input longint size,
                                             input longint centre);
    longint v;
    v = ((trig * size + 64'sd536870912) >>> 30) + centre;
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return v[31:0];
  endfunction

  // point on the ellipse for one time stamp under the shadow configuration
  function automatic point_t predict_point(input logic [47:0] stamp);
    logic [63:0] spd;
    logic [63:0] phs;
    logic [63:0] rad_prod;
    logic [63:0] turn_prod;
    logic [63:0] phase_prod;
    logic [31:0] angle;
    logic        flip;
    longint      cx;
    longint      cy;
    longint      cz;
    longint      dx;
    longint      dy;
    point_t      pt;
    spd = shadow_speed;
    phs = shadow_phase;
    // time times speed, then radians to turns; only the wrapped turn survives
    rad_prod = {16'd0, stamp} * spd;
    turn_prod = rad_prod * 64'd683565276;
    phase_prod = phs * 64'd11930465;
    angle = turn_prod[63:32] + phase_prod[39:8];
    // left half plane: rotate by half a turn and negate afterwards
    flip = angle[31] ^ angle[30];
    if (flip) angle[31] = ~angle[31];
    cz = longint'(signed'(angle));
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < ROT_STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - atan_step[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + atan_step[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    pt.x = scale_axis(cx, shadow_size_x, shadow_center_x);
    pt.y = scale_axis(cy, shadow_size_y, shadow_center_y);
    return pt;
  endfunction

  // mostly short idle spells, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [47:0] random_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) return 48'($urandom_range(0, 32'h000F_FFFF));
    return r[47:0];
  endfunction

  // register value biased towards the range ends, zero and modest magnitudes
  function automatic logic [31:0] pick_reg_value(input logic [31:0] hi, input logic [31:0] lo);
    case ($urandom_range(0, 7))
      0: return hi;
      1: return lo;
      2: return '0;
      3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h003F_FFFF)
                                     : -$urandom_range(0, 32'h003F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 200) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // one configuration transaction, valid left high for the next one
  task automatic push_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // full register set, preceded by a write the block must ignore
  task automatic program_regs(input cfg_set_t s);
    push_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom());
    push_reg(epg_pkg::REG_SIZE_X, s.size_x);
    push_reg(epg_pkg::REG_SIZE_Y, s.size_y);
    push_reg(epg_pkg::REG_CENTER_X, s.center_x);
    push_reg(epg_pkg::REG_CENTER_Y, s.center_y);
    push_reg(epg_pkg::REG_SPEED, s.speed);
    push_reg(epg_pkg::REG_PHASE_DEG, s.phase);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off until every sent stamp has been answered, checked between edges
  task automatic drain();
    while (stamps_to_send.size() != 0 || in_valid_i || points_due.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // input driver: send queued stamps, hold while stalled, idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      time_stamp_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) points_due.push_back(predict_point(time_stamp_i));
      if (in_valid_i && in_stall_o) begin
        // payload held until the transaction completes
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (stamps_to_send.size() != 0) begin
        in_valid_i <= 1'b1;
        time_stamp_i <= stamps_to_send.pop_front();
        send_gap <= (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // shadow registers follow accepted configuration transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_size_x <= 65536;
      shadow_size_y <= 65536;
      shadow_center_x <= 0;
      shadow_center_y <= 0;
      shadow_speed <= 6554;
      shadow_phase <= 0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        epg_pkg::REG_SIZE_X:    shadow_size_x <= longint'(signed'(cfg_data_i));
        epg_pkg::REG_SIZE_Y:    shadow_size_y <= longint'(signed'(cfg_data_i));
        epg_pkg::REG_CENTER_X:  shadow_center_x <= longint'(signed'(cfg_data_i));
        epg_pkg::REG_CENTER_Y:  shadow_center_y <= longint'(signed'(cfg_data_i));
        epg_pkg::REG_SPEED:     shadow_speed <= longint'(signed'(cfg_data_i[23:0]));
        epg_pkg::REG_PHASE_DEG: shadow_phase <= longint'(signed'(cfg_data_i[19:0]));
        default: begin
        end
      endcase
    end
  end

  // output monitor: compare each point with the oldest one owed, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (points_due.size() == 0) begin
          report_mismatch($sformatf("point %h,%h with none outstanding", point_x_o, point_y_o));
        end else begin
          oldest_point = points_due.pop_front();
          if (point_x_o !== oldest_point.x)
            report_mismatch($sformatf("point_x got %h expected %h", point_x_o, oldest_point.x));
          if (point_y_o !== oldest_point.y)
            report_mismatch($sformatf("point_y got %h expected %h", point_y_o, oldest_point.y));
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
    end
  end

  // stimulus sequence
  initial begin
    cfg_set_t    plan;
    int unsigned n_items;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, time stamp extremes
    stamps_to_send.push_back(48'h0000_0000_0000);
    stamps_to_send.push_back(48'hFFFF_FFFF_FFFF);
    stamps_to_send.push_back(48'h0000_0000_0001);
    stamps_to_send.push_back(48'h8000_0000_0000);
    stamps_to_send.push_back(48'h0000_0001_0000);
    stamps_to_send.push_back(random_stamp());
    drain();

    // unit speed with junk above the speed and phase fields; quadrant boundaries
    plan = '{size_x: 32'h0001_0000, size_y: 32'h0002_0000, center_x: '0, center_y: '0,
             speed: 32'hA501_0000, phase: 32'hFFF0_0000};
    program_regs(plan);
    stamps_to_send.push_back(48'd0);
    stamps_to_send.push_back(48'd102943);
    stamps_to_send.push_back(48'd102944);
    stamps_to_send.push_back(48'd205887);
    stamps_to_send.push_back(48'd308831);
    stamps_to_send.push_back(48'd308832);
    stamps_to_send.push_back(48'd411775);
    stamps_to_send.push_back(48'hFFFF_FFFF_FFFF);
    drain();

    // upper extremes on x, speed and phase, lower extremes on y, saturating sums
    plan = '{size_x: 32'h7FFF_FFFF, size_y: 32'h8000_0000, center_x: 32'h7FFF_FFFF,
             center_y: 32'h8000_0000, speed: 32'h007F_FFFF, phase: 32'h0007_FFFF};
    program_regs(plan);
    stamps_to_send.push_back(48'h0000_0000_0000);
    stamps_to_send.push_back(48'hFFFF_FFFF_FFFF);
    stamps_to_send.push_back(48'h5555_5555_5555);
    stamps_to_send.push_back(48'hAAAA_AAAA_AAAA);
    stamps_to_send.push_back(random_stamp());
    drain();

    // lower extremes, mirrored
    plan = '{size_x: 32'h8000_0000, size_y: 32'h7FFF_FFFF, center_x: 32'h8000_0000,
             center_y: 32'h7FFF_FFFF, speed: 32'h0080_0000, phase: 32'h0008_0000};
    program_regs(plan);
    stamps_to_send.push_back(48'h0000_0000_0000);
    stamps_to_send.push_back(48'hFFFF_FFFF_FFFF);
    stamps_to_send.push_back(48'h8000_0000_0000);
    stamps_to_send.push_back(48'h0000_0001_0000);
    stamps_to_send.push_back(random_stamp());
    drain();

    // random configurations, each followed by a burst of random stamps
    for (int ph = 0; ph < 8; ph++) begin
      plan.size_x = pick_reg_value(32'h7FFF_FFFF, 32'h8000_0000);
      plan.size_y = pick_reg_value(32'h7FFF_FFFF, 32'h8000_0000);
      plan.center_x = pick_reg_value(32'h7FFF_FFFF, 32'h8000_0000);
      plan.center_y = pick_reg_value(32'h7FFF_FFFF, 32'h8000_0000);
      plan.speed = pick_reg_value(32'h007F_FFFF, 32'h0080_0000);
      plan.phase = pick_reg_value(32'h0007_FFFF, 32'h0008_0000);
      program_regs(plan);
      no_idle = (ph == 3);
      n_items = $urandom_range(90, 130);
      repeat (n_items) stamps_to_send.push_back(random_stamp());
      drain();
    end

    // let any stray point surface before the verdict
    no_idle = 1'b0;
    repeat (PIPE_DEPTH + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
